>>> rtl/b91_pkg.sv
// ----------------------------------------------------------------------------
// b91_pkg
// Shared types, constants and the alphabet lookup for the basE91 encoder.
// ----------------------------------------------------------------------------
package b91_pkg;

    localparam int B91_QUEUE_W = 21;
    localparam int B91_COUNT_W = 5;
    localparam int B91_VAL_W   = 14;
    localparam int B91_CHAR_W  = 7;
    localparam int B91_PROD_W  = 28;

    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    localparam logic [B91_COUNT_W-1:0] B91_TAKE_MAX    = 5'd13;
    localparam logic [B91_COUNT_W-1:0] B91_BYTE_BITS   = 5'd8;
    localparam logic [B91_COUNT_W-1:0] B91_SHORT_TAKE  = 5'd13;
    localparam logic [B91_COUNT_W-1:0] B91_LONG_TAKE   = 5'd14;
    localparam logic [B91_COUNT_W-1:0] B91_ONE_CHAR_BITS = 5'd7;
    localparam logic [12:0]            B91_SMALL_LIMIT = 13'd88;
    localparam logic [B91_VAL_W-1:0]   B91_ONE_CHAR_MAX = 14'd90;

    // floor(v / 91) == (v * RECIP) >> SHIFT for every 14-bit v
    localparam logic [B91_VAL_W-1:0] B91_RECIP       = 14'd11523;
    localparam int                   B91_RECIP_SHIFT = 20;
    localparam logic [7:0]           B91_RADIX       = 8'd91;

    localparam logic [B91_CHAR_W-1:0] B91_UPPER_BASE = 7'd65;
    localparam logic [B91_CHAR_W-1:0] B91_LOWER_BASE = 7'd97;
    localparam logic [B91_CHAR_W-1:0] B91_DIGIT_BASE = 7'd48;

    localparam int B91_SPECIAL_N = 29;
    localparam logic [B91_CHAR_W-1:0] B91_SPECIAL [B91_SPECIAL_N] = '{
        7'd33, 7'd35, 7'd36, 7'd37, 7'd38, 7'd40, 7'd41, 7'd42, 7'd43, 7'd44,
        7'd46, 7'd47, 7'd58, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd91,
        7'd93, 7'd94, 7'd95, 7'd96, 7'd123, 7'd124, 7'd125, 7'd126, 7'd34
    };

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } b91_in_t;

    typedef struct packed {
        logic [B91_CHAR_W-1:0] out_char;
        logic                  last;
    } b91_out_t;

    typedef struct packed {
        logic [B91_VAL_W-1:0] val;
        logic                 two;
    } b91_entry_t;

    function automatic logic [B91_CHAR_W-1:0] b91_glyph(input logic [B91_CHAR_W-1:0] idx);
        logic [B91_CHAR_W-1:0] off;
        logic [4:0]            sidx;
        logic [B91_CHAR_W-1:0] ch;
        off  = idx - 7'd62;
        sidx = off[4:0];
        if (idx < 7'd26) begin
            ch = B91_UPPER_BASE + idx;
        end else if (idx < 7'd52) begin
            ch = B91_LOWER_BASE + (idx - 7'd26);
        end else if (idx < 7'd62) begin
            ch = B91_DIGIT_BASE + (idx - 7'd52);
        end else if (off < 7'(B91_SPECIAL_N)) begin
            ch = B91_SPECIAL[sidx];
        end else begin
            ch = B91_UPPER_BASE;
        end
        return ch;
    endfunction

endpackage

>>> rtl/b91_front.sv
// ----------------------------------------------------------------------------
// b91_front
// Bit queue: accepts bytes and flushes, cuts 13/14-bit values, queues them.
// ----------------------------------------------------------------------------
module b91_front
    import b91_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  b91_in_t                s_data,
    input  logic                   fifo_full,
    output logic                   push,
    output b91_entry_t             push_entry,
    output logic [B91_COUNT_W-1:0] bit_count
);

    logic [B91_QUEUE_W-1:0] queue_reg, queue_next;
    logic [B91_COUNT_W-1:0] count_reg, count_next;
    logic [B91_QUEUE_W-1:0] merged;
    logic [B91_COUNT_W-1:0] sum;
    logic                   take_long;
    logic                   accept;

    assign s_ready   = !fifo_full;
    assign accept    = s_valid && s_ready;
    assign bit_count = count_reg;

    always_comb begin
        merged    = queue_reg | (B91_QUEUE_W'(s_data.data_byte) << count_reg);
        sum       = count_reg + B91_BYTE_BITS;
        take_long = merged[12:0] <= B91_SMALL_LIMIT;

        queue_next = queue_reg;
        count_next = count_reg;
        push       = 1'b0;
        push_entry = '0;

        if (accept) begin
            if (s_data.action == ACT_DATA) begin
                if (sum > B91_TAKE_MAX) begin
                    push           = 1'b1;
                    push_entry.two = 1'b1;
                    if (take_long) begin
                        push_entry.val = merged[B91_VAL_W-1:0];
                        queue_next     = merged >> 14;
                        count_next     = sum - B91_LONG_TAKE;
                    end else begin
                        push_entry.val = {1'b0, merged[12:0]};
                        queue_next     = merged >> 13;
                        count_next     = sum - B91_SHORT_TAKE;
                    end
                end else begin
                    queue_next = merged;
                    count_next = sum;
                end
            end else begin
                push_entry.val = queue_reg[B91_VAL_W-1:0];
                push_entry.two = (count_reg > B91_ONE_CHAR_BITS) ||
                                 (queue_reg[B91_VAL_W-1:0] > B91_ONE_CHAR_MAX);
                push           = count_reg != '0;
                queue_next     = '0;
                count_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queue_reg <= '0;
            count_reg <= '0;
        end else begin
            queue_reg <= queue_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/b91_fifo.sv
// ----------------------------------------------------------------------------
// b91_fifo
// Short show-ahead queue of cut values between front and back.
// ----------------------------------------------------------------------------
module b91_fifo
    import b91_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  b91_entry_t                   push_entry,
    output logic                         full,
    output logic                         pop_valid,
    input  logic                         pop,
    output b91_entry_t                   pop_entry,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    b91_entry_t      mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = count_reg == CW'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_entry = mem[rd_ptr_reg];
    assign level     = count_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/b91_back.sv
// ----------------------------------------------------------------------------
// b91_back
// Splits each value into two base-91 digits and sends one or both characters.
// ----------------------------------------------------------------------------
module b91_back
    import b91_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       pop_valid,
    output logic       pop,
    input  b91_entry_t pop_entry,
    output logic       m_valid,
    input  logic       m_ready,
    output b91_out_t   m_data
);

    logic                  a_valid_reg, a_valid_next;
    logic [B91_VAL_W-1:0]  a_val_reg, a_val_next;
    logic [B91_PROD_W-1:0] a_prod_reg, a_prod_next;
    logic                  a_two_reg, a_two_next;

    logic                  b_valid_reg, b_valid_next;
    logic                  b_phase_reg, b_phase_next;
    logic                  b_two_reg, b_two_next;
    logic [B91_CHAR_W-1:0] b_char0_reg, b_char0_next;
    logic [B91_CHAR_W-1:0] b_char1_reg, b_char1_next;

    logic                  b_last;
    logic                  b_done;
    logic                  b_load;
    logic                  a_load;
    logic [7:0]            quo;
    logic [7:0]            quo_wrap;
    logic [B91_VAL_W-1:0]  rem;

    assign b_last  = b_phase_reg || !b_two_reg;
    assign b_done  = b_valid_reg && m_ready && b_last;
    assign b_load  = a_valid_reg && (!b_valid_reg || b_done);
    assign a_load  = !a_valid_reg || b_load;
    assign pop     = pop_valid && a_load;

    assign m_valid         = b_valid_reg;
    assign m_data.out_char = b_phase_reg ? b_char1_reg : b_char0_reg;
    assign m_data.last     = b_last;

    always_comb begin
        quo      = a_prod_reg[B91_RECIP_SHIFT +: 8];
        rem      = a_val_reg - B91_VAL_W'(16'(quo) * 16'(B91_RADIX));
        quo_wrap = (quo >= B91_RADIX) ? quo - B91_RADIX : quo;

        a_valid_next = a_valid_reg;
        a_val_next   = a_val_reg;
        a_prod_next  = a_prod_reg;
        a_two_next   = a_two_reg;
        if (a_load) begin
            a_valid_next = pop_valid;
            a_val_next   = pop_entry.val;
            a_prod_next  = B91_PROD_W'(pop_entry.val) * B91_PROD_W'(B91_RECIP);
            a_two_next   = pop_entry.two;
        end

        b_valid_next = b_valid_reg;
        b_phase_next = b_phase_reg;
        b_two_next   = b_two_reg;
        b_char0_next = b_char0_reg;
        b_char1_next = b_char1_reg;
        if (b_valid_reg && m_ready) begin
            b_phase_next = 1'b1;
            if (b_last) begin
                b_valid_next = 1'b0;
            end
        end
        if (b_load) begin
            b_valid_next = 1'b1;
            b_phase_next = 1'b0;
            b_two_next   = a_two_reg;
            b_char0_next = b91_glyph(rem[B91_CHAR_W-1:0]);
            b_char1_next = b91_glyph(quo_wrap[B91_CHAR_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        a_val_reg   <= a_val_next;
        a_prod_reg  <= a_prod_next;
        a_two_reg   <= a_two_next;
        b_two_reg   <= b_two_next;
        b_char0_reg <= b_char0_next;
        b_char1_reg <= b_char1_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_phase_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            b_phase_reg <= b_phase_next;
        end
    end

endmodule

>>> rtl/base91_stream_encoder_unit.sv
// ----------------------------------------------------------------------------
// base91_stream_encoder_unit
// basE91 encoder: bytes in, alphabet characters out, flush ends a stream.
// ----------------------------------------------------------------------------
// Each input beat carries either a data byte or a flush. A byte that fills the
// bit queue past 13 bits yields two characters; a flush yields zero, one or
// two characters and clears the queue. The last flag marks the final character
// of the beat that caused it. One character leaves per cycle on the result
// port while m_ready is high; the front end takes new bytes while earlier
// characters are still leaving, until the queue is full. The first character
// of a value passes the queue write, then the digit multiply register, then
// the output register before it is presented. FIFO_DEPTH (at least 2) sets how
// many cut values the queue between the bit-queue front end and the character
// back end can hold.
// ----------------------------------------------------------------------------
module base91_stream_encoder_unit
    import b91_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  b91_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output b91_out_t m_data
);

    logic                             fifo_full;
    logic                             push;
    b91_entry_t                       push_entry;
    logic                             pop_valid;
    logic                             pop;
    b91_entry_t                       pop_entry;
    logic [$clog2(FIFO_DEPTH+1)-1:0]  fifo_level;
    logic [B91_COUNT_W-1:0]           bit_count;

    b91_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry),
        .bit_count  (bit_count)
    );

    b91_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .level      (fifo_level)
    );

    b91_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_entry (pop_entry),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count <= B91_TAKE_MAX)
        else $error("bit queue count above 13");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.action == ACT_FLUSH) |=> bit_count == '0)
        else $error("flush left bits queued");

    a_cut_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.action == ACT_DATA && bit_count >= 5'd6)
        |=> fifo_level != '0)
        else $error("cut value not queued");

endmodule
